### rtl/core/first_fit_segment_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit segment allocator
// Clocked property checks used by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// check held at every edge outside reset
`define FFSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check held at every edge, reset included
`define FFSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ffsa_pkg.sv
// ---------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes of the first-fit segment allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

   localparam int REQ_W   = 24;  // req tdata width
   localparam int RSP_W   = 24;  // rsp tdata width
   localparam int SIZE_W  = 11;
   localparam int ADDR_W  = 10;
   localparam int TOTAL_W = 11;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_BIG   = 3'd1,
      ST_NO_FREE   = 3'd2,
      ST_NO_FIT    = 3'd3,
      ST_OVER_USED = 3'd4,
      ST_OVERLAP   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_FAIL,
      OP_SCAN_START,
      OP_SCAN,
      OP_APPLY,
      OP_APPLY2,
      OP_CMP_START,
      OP_CMP,
      OP_CMP_END,
      OP_PUSH
   } op_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_APPLY,
      S_APPLY2,
      S_CMP_START,
      S_CMP,
      S_CMP_END,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pre_ok;     // request passes the size/total checks
      logic scan_done;  // no read in flight and nothing left to read
      logic apply_ok;   // scan result allows the table update
      logic both_nbr;   // free merges with both neighbors
      logic cmp_done;   // compaction pass finished
      logic rsp_busy;   // output register full and not taken
   } stat_type;

endpackage

`default_nettype wire

### rtl/core/first_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over a pool, free segments kept in a table, coalescing.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                  | tuser
//  req     | in  | req_size[10:0], req_addr[20:11]     | req_type (0 alloc, 1 free)
//  rsp     | out | alloc_addr[9:0], allocated_total[20:10] | status[2:0]
//
//  One item at a time: an item that passes its checks makes two passes over
//  the segment RAM (scan, then compaction) at one read a cycle; a failed
//  check ends the item without the passes that remain.
//  After reset the S_INIT state writes the initial whole-pool segment;
//  req_tready stays low until then.
//  The result register lets the next item in while a result waits; only
//  the push of the following result stalls on rsp_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator #(
   parameter int POOL_SIZE    = 1024,
   parameter int MAX_SEGMENTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // req_size[10:0], req_addr[20:11], zero pad
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // alloc_addr[9:0], allocated_total[20:10], zero pad
   output logic [2:0]       rsp_tuser    // status
);

   ffsa_pkg::cmd_type    cmd;
   ffsa_pkg::stat_type   stat;
   ffsa_pkg::status_type rsp_status;
   logic [ffsa_pkg::ADDR_W-1:0]  rsp_addr;
   logic [ffsa_pkg::TOTAL_W-1:0] rsp_total;

   // sequencer
   ffsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // segment table and result register
   ffsa_dp #(
      .POOL_SIZE    (POOL_SIZE),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_size   (req_tdata[10:0]),
      .req_addr   (req_tdata[20:11]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_addr   (rsp_addr),
      .rsp_total  (rsp_total)
   );

   assign rsp_tdata = {3'b000, rsp_total, rsp_addr};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

### rtl/core/ffsa_ram.sv
// ---------------------------------------------------------------------------
// ffsa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/ffsa_ctrl.sv
// ---------------------------------------------------------------------------
// ffsa_ctrl
// Request sequencer: checks, table scan, update, compaction, result push.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire ffsa_pkg::stat_type stat,
   output ffsa_pkg::cmd_type      cmd
);

   ffsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = ffsa_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ffsa_pkg::S_INIT: begin
            cmd.op   = ffsa_pkg::OP_INIT;
            state_in = ffsa_pkg::S_IDLE;
         end
         ffsa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = ffsa_pkg::OP_LOAD;
               state_in = ffsa_pkg::S_CHECK;
            end
         end
         ffsa_pkg::S_CHECK: begin
            if (!stat.pre_ok) begin
               cmd.op   = ffsa_pkg::OP_FAIL;
               state_in = ffsa_pkg::S_FINISH;
            end else begin
               cmd.op   = ffsa_pkg::OP_SCAN_START;
               state_in = ffsa_pkg::S_SCAN;
            end
         end
         ffsa_pkg::S_SCAN: begin
            cmd.op = ffsa_pkg::OP_SCAN;
            if (stat.scan_done) begin
               state_in = ffsa_pkg::S_APPLY;
            end
         end
         ffsa_pkg::S_APPLY: begin
            if (!stat.apply_ok) begin
               cmd.op   = ffsa_pkg::OP_FAIL;
               state_in = ffsa_pkg::S_FINISH;
            end else begin
               cmd.op   = ffsa_pkg::OP_APPLY;
               state_in = stat.both_nbr ? ffsa_pkg::S_APPLY2 : ffsa_pkg::S_CMP_START;
            end
         end
         ffsa_pkg::S_APPLY2: begin
            cmd.op   = ffsa_pkg::OP_APPLY2;
            state_in = ffsa_pkg::S_CMP_START;
         end
         ffsa_pkg::S_CMP_START: begin
            cmd.op   = ffsa_pkg::OP_CMP_START;
            state_in = ffsa_pkg::S_CMP;
         end
         ffsa_pkg::S_CMP: begin
            cmd.op = ffsa_pkg::OP_CMP;
            if (stat.cmp_done) begin
               state_in = ffsa_pkg::S_CMP_END;
            end
         end
         ffsa_pkg::S_CMP_END: begin
            cmd.op   = ffsa_pkg::OP_CMP_END;
            state_in = ffsa_pkg::S_FINISH;
         end
         ffsa_pkg::S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = ffsa_pkg::OP_PUSH;
               state_in = ffsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffsa_pkg::S_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/ffsa_dp.sv
// ---------------------------------------------------------------------------
// ffsa_dp
// Segment table, totals, scan/compaction pointers and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "first_fit_segment_allocator_macros.svh"

module ffsa_dp #(
   parameter int POOL_SIZE    = 1024,
   parameter int MAX_SEGMENTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ffsa_pkg::cmd_type               cmd,
   output ffsa_pkg::stat_type                   stat,
   input  wire logic                            req_kind,
   input  wire logic [ffsa_pkg::SIZE_W-1:0]     req_size,
   input  wire logic [ffsa_pkg::ADDR_W-1:0]     req_addr,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output ffsa_pkg::status_type                 rsp_status,
   output logic [ffsa_pkg::ADDR_W-1:0]          rsp_addr,
   output logic [ffsa_pkg::TOTAL_W-1:0]         rsp_total
);

   localparam int PW = $clog2(POOL_SIZE + 1);         // start/length width
   localparam int SW = (PW + 1 > 12) ? PW + 1 : 12;   // compare/sum width
   localparam int CW = $clog2(MAX_SEGMENTS + 1);      // count width
   localparam int IW = $clog2(MAX_SEGMENTS);          // table index width
   localparam logic [SW-1:0] POOL_S = SW'(POOL_SIZE);
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_SEGMENTS);

   // request
   logic              kind_ff, kind_in;
   logic [SW-1:0]     size_ff, size_in;
   logic [SW-1:0]     addr_ff, addr_in;
   logic [SW-1:0]     end_ff, end_in;
   // table state
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     used_ff, used_in;
   // pointers
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rv_ff, rv_in;
   logic [IW-1:0]     rv_idx_ff, rv_idx_in;
   logic [CW-1:0]     wj_ff, wj_in;
   logic [2*PW-1:0]   last_ff, last_in;
   // scan findings
   logic              found_ff, found_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;
   logic [PW-1:0]     hit_start_ff, hit_start_in;
   logic [PW-1:0]     hit_len_ff, hit_len_in;
   logic              overlap_ff, overlap_in;
   logic              prev_ok_ff, prev_ok_in;
   logic [IW-1:0]     prev_idx_ff, prev_idx_in;
   logic [PW-1:0]     prev_start_ff, prev_start_in;
   logic [PW-1:0]     prev_len_ff, prev_len_in;
   logic              next_ok_ff, next_ok_in;
   logic [IW-1:0]     next_idx_ff, next_idx_in;
   logic [PW-1:0]     next_len_ff, next_len_in;
   // result
   ffsa_pkg::status_type res_status_ff, res_status_in;
   logic [PW-1:0]     res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ffsa_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [ffsa_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // ram
   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr;
   logic [2*PW-1:0]   wr_data, rd_data;
   logic [PW-1:0]     ent_start, ent_len;
   logic [SW-1:0]     ent_s, ent_e;
   logic              issue;
   ffsa_pkg::status_type pre_code, apply_code;
   logic [SW-1:0]     res_addr_ext, used_ext;

   ffsa_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign ent_start = rd_data[2*PW-1:PW];
   assign ent_len   = rd_data[PW-1:0];
   assign ent_s     = SW'(ent_start);
   assign ent_e     = SW'(ent_start) + SW'(ent_len);
   assign used_ext  = SW'(used_ff);

   // checks that need no table access
   always_comb begin
      pre_code = ffsa_pkg::ST_OK;
      if (size_ff > POOL_S) begin
         pre_code = ffsa_pkg::ST_TOO_BIG;
      end else if (kind_ff == ffsa_pkg::REQ_ALLOC) begin
         if (size_ff + used_ext > POOL_S) begin
            pre_code = ffsa_pkg::ST_NO_FREE;
         end
      end else if (size_ff > used_ext) begin
         pre_code = ffsa_pkg::ST_OVER_USED;
      end else if (end_ff > POOL_S) begin
         pre_code = ffsa_pkg::ST_OVERLAP;
      end
   end

   always_comb begin
      apply_code = ffsa_pkg::ST_OK;
      if (kind_ff == ffsa_pkg::REQ_ALLOC) begin
         if (!found_ff) begin
            apply_code = ffsa_pkg::ST_NO_FIT;
         end
      end else if (overlap_ff) begin
         apply_code = ffsa_pkg::ST_OVERLAP;
      end else if (!prev_ok_ff && !next_ok_ff && count_ff >= MAX_C) begin
         apply_code = ffsa_pkg::ST_FULL;
      end
   end

   assign issue = ((cmd.op == ffsa_pkg::OP_SCAN) && (idx_ff < count_ff) && !found_ff) ||
                  ((cmd.op == ffsa_pkg::OP_CMP) && (idx_ff < count_ff));
   assign rd_en = issue;

   always_comb begin
      stat.pre_ok    = (pre_code == ffsa_pkg::ST_OK);
      stat.scan_done = !rv_ff && ((idx_ff == count_ff) || found_ff);
      stat.apply_ok  = (apply_code == ffsa_pkg::ST_OK);
      stat.both_nbr  = (kind_ff == ffsa_pkg::REQ_FREE) && prev_ok_ff && next_ok_ff;
      stat.cmp_done  = !rv_ff && (idx_ff == count_ff);
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      rv_in         = 1'b0;
      rv_idx_in     = idx_ff[IW-1:0];
      wj_in         = wj_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_start_in  = hit_start_ff;
      hit_len_in    = hit_len_ff;
      overlap_in    = overlap_ff;
      prev_ok_in    = prev_ok_ff;
      prev_idx_in   = prev_idx_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      next_ok_in    = next_ok_ff;
      next_idx_in   = next_idx_ff;
      next_len_in   = next_len_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      res_addr_ext  = SW'(res_addr_ff);

      case (cmd.op)
         ffsa_pkg::OP_INIT: begin
            wr_en   = 1'b1;
            wr_data = {PW'(0), PW'(POOL_SIZE)};
         end
         ffsa_pkg::OP_LOAD: begin
            kind_in       = req_kind;
            size_in       = SW'(req_size);
            addr_in       = SW'(req_addr);
            end_in        = SW'(req_addr) + SW'(req_size);
            found_in      = 1'b0;
            res_status_in = ffsa_pkg::ST_OK;
            res_addr_in   = '0;
         end
         ffsa_pkg::OP_FAIL: begin
            res_status_in = stat.pre_ok ? apply_code : pre_code;
         end
         ffsa_pkg::OP_SCAN_START: begin
            idx_in     = '0;
            found_in   = 1'b0;
            overlap_in = 1'b0;
            prev_ok_in = 1'b0;
            next_ok_in = 1'b0;
         end
         ffsa_pkg::OP_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
               rv_in  = 1'b1;
            end
            if (rv_ff && !found_ff) begin
               if (kind_ff == ffsa_pkg::REQ_ALLOC) begin
                  if (size_ff <= SW'(ent_len)) begin
                     found_in     = 1'b1;
                     hit_idx_in   = rv_idx_ff;
                     hit_start_in = ent_start;
                     hit_len_in   = ent_len;
                  end
               end else begin
                  if ((ent_s < addr_ff && ent_e > addr_ff) ||
                      (ent_s > addr_ff && ent_s < end_ff) || ent_s == addr_ff) begin
                     overlap_in = 1'b1;
                  end
                  if (!next_ok_ff && ent_s == end_ff) begin
                     next_ok_in  = 1'b1;
                     next_idx_in = rv_idx_ff;
                     next_len_in = ent_len;
                  end
                  if (!prev_ok_ff && ent_e == addr_ff) begin
                     prev_ok_in    = 1'b1;
                     prev_idx_in   = rv_idx_ff;
                     prev_start_in = ent_start;
                     prev_len_in   = ent_len;
                  end
               end
            end
         end
         ffsa_pkg::OP_APPLY: begin
            wr_en = 1'b1;
            if (kind_ff == ffsa_pkg::REQ_ALLOC) begin
               wr_addr     = hit_idx_ff;
               wr_data     = {hit_start_ff + size_ff[PW-1:0], hit_len_ff - size_ff[PW-1:0]};
               used_in     = used_ff + size_ff[PW-1:0];
               res_addr_in = hit_start_ff;
            end else begin
               used_in = used_ff - size_ff[PW-1:0];
               if (prev_ok_ff) begin
                  wr_addr = prev_idx_ff;
                  wr_data = {prev_start_ff,
                             prev_len_ff + size_ff[PW-1:0] + (next_ok_ff ? next_len_ff : '0)};
               end else if (next_ok_ff) begin
                  wr_addr = next_idx_ff;
                  wr_data = {addr_ff[PW-1:0], next_len_ff + size_ff[PW-1:0]};
               end else begin
                  wr_addr  = count_ff[IW-1:0];
                  wr_data  = {addr_ff[PW-1:0], size_ff[PW-1:0]};
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ffsa_pkg::OP_APPLY2: begin
            // following segment was absorbed: empty it, compaction drops it
            wr_en   = 1'b1;
            wr_addr = next_idx_ff;
            wr_data = {addr_ff[PW-1:0], PW'(0)};
         end
         ffsa_pkg::OP_CMP_START: begin
            idx_in = '0;
            wj_in  = '0;
         end
         ffsa_pkg::OP_CMP: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
               rv_in  = 1'b1;
            end
            if (rv_ff) begin
               last_in = rd_data;
               if (ent_len != '0) begin
                  wr_en   = 1'b1;
                  wr_addr = wj_ff[IW-1:0];
                  wr_data = rd_data;
                  wj_in   = wj_ff + 1'b1;
               end
            end
         end
         ffsa_pkg::OP_CMP_END: begin
            // all empty: the last entry stays as the lone segment
            if (wj_ff == '0) begin
               wr_en    = 1'b1;
               wr_data  = last_ff;
               count_in = CW'(1);
            end else begin
               count_in = wj_ff;
            end
         end
         ffsa_pkg::OP_PUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_addr_in   = res_addr_ext[ffsa_pkg::ADDR_W-1:0];
            used_ext_cut: begin
               rsp_total_in = used_ext[ffsa_pkg::TOTAL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         used_ff      <= '0;
         rv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         used_ff      <= used_in;
         rv_ff        <= rv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      end_ff        <= end_in;
      idx_ff        <= idx_in;
      rv_idx_ff     <= rv_idx_in;
      wj_ff         <= wj_in;
      last_ff       <= last_in;
      hit_idx_ff    <= hit_idx_in;
      hit_start_ff  <= hit_start_in;
      hit_len_ff    <= hit_len_in;
      overlap_ff    <= overlap_in;
      prev_ok_ff    <= prev_ok_in;
      prev_idx_ff   <= prev_idx_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      next_ok_ff    <= next_ok_in;
      next_idx_ff   <= next_idx_in;
      next_len_ff   <= next_len_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_total  = rsp_total_ff;

   `FFSA_ASSERT(a_count_range, clock, reset, (count_ff != '0) && (count_ff <= MAX_C), "segment count out of range")
   `FFSA_ASSERT(a_used_range, clock, reset, SW'(used_ff) <= POOL_S, "allocated total exceeds pool")
   `FFSA_ASSERT(a_push_free, clock, reset, (cmd.op == ffsa_pkg::OP_PUSH) |-> (!rsp_valid_ff || rsp_ready), "result overwritten before taken")
   `FFSA_ASSERT(a_hit_alloc, clock, reset, found_ff |-> (kind_ff == ffsa_pkg::REQ_ALLOC), "fit found on a free request")

endmodule

`default_nettype wire

### test/tb_first_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// tb_first_fit_segment_allocator
// Self-checking bench for the first-fit segment allocator: a cycle-free
// model of the free-segment table predicts every response item, a checker
// compares them in order, and both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;

   localparam int POOL     = 1024;
   localparam int SEGS     = 16;
   localparam int LIMIT    = 1000000;  // cycles before the watchdog fires
   localparam int N_RANDOM = 1800;

   typedef struct {
      ffsa_pkg::status_type status;
      logic [9:0]           addr;
      logic [10:0]          total;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // req_size[10:0], req_addr[20:11], zero pad
   logic        req_tuser = 1'b0; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // alloc_addr[9:0], allocated_total[20:10], zero pad
   logic [2:0]  rsp_tuser;        // status

   // model of the free-segment table
   int seg_base [SEGS];
   int seg_len  [SEGS];
   int seg_cnt;
   int units_used;

   grant_type expected_grants[$];
   int     errors     = 0;
   int     cycles     = 0;
   bit     quiet      = 1'b0;  // no random idling on either side while set
   int     hold_left  = 0;     // receiver hold-off, in cycles

   first_fit_segment_allocator #(.POOL_SIZE(POOL), .MAX_SEGMENTS(SEGS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("watchdog: %0d cycles, %0d items outstanding", cycles,
                  expected_grants.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // table model
   // ------------------------------------------------------------------------
   function automatic void drop_seg(input int idx);
      for (int k = idx; k + 1 < seg_cnt; k++) begin
         seg_base[k] = seg_base[k+1];
         seg_len[k]  = seg_len[k+1];
      end
      seg_cnt--;
   endfunction

   // empty entries go, but one entry always stays
   function automatic void squeeze_table();
      int k;
      k = 0;
      while (k < seg_cnt && seg_cnt > 1) begin
         if (seg_len[k] == 0) drop_seg(k);
         else k++;
      end
   endfunction

   function automatic ffsa_pkg::status_type model_alloc(input int size, output int got);
      got = 0;
      if (size > POOL) return ffsa_pkg::ST_TOO_BIG;
      if (size + units_used > POOL) return ffsa_pkg::ST_NO_FREE;
      for (int k = 0; k < seg_cnt; k++) begin
         if (size <= seg_len[k]) begin
            got = seg_base[k];
            seg_base[k] += size;
            seg_len[k]  -= size;
            units_used  += size;
            squeeze_table();
            return ffsa_pkg::ST_OK;
         end
      end
      return ffsa_pkg::ST_NO_FIT;
   endfunction

   function automatic ffsa_pkg::status_type model_free(input int size, input int addr);
      int  s, e, fin, pi, ni;
      bit  hp, hn;
      fin = addr + size;
      hp = 0; hn = 0; pi = 0; ni = 0;
      if (size > POOL) return ffsa_pkg::ST_TOO_BIG;
      if (size > units_used) return ffsa_pkg::ST_OVER_USED;
      if (fin > POOL) return ffsa_pkg::ST_OVERLAP;
      for (int k = 0; k < seg_cnt; k++) begin
         s = seg_base[k];
         e = s + seg_len[k];
         if ((s < addr && e > addr) || (s > addr && s < fin) || s == addr)
            return ffsa_pkg::ST_OVERLAP;
      end
      for (int k = 0; k < seg_cnt; k++) begin
         s = seg_base[k];
         e = s + seg_len[k];
         if (!hn && s == fin) begin hn = 1; ni = k; end
         if (!hp && e == addr) begin hp = 1; pi = k; end
      end
      if (hp && hn) begin
         // preceding segment swallows range and follower, follower goes
         seg_len[pi] += size + seg_len[ni];
         drop_seg(ni);
      end else if (hp) begin
         seg_len[pi] += size;
      end else if (hn) begin
         seg_base[ni] = addr;
         seg_len[ni] += size;
      end else begin
         if (seg_cnt >= SEGS) return ffsa_pkg::ST_FULL;
         seg_base[seg_cnt] = addr;
         seg_len[seg_cnt]  = size;
         seg_cnt++;
      end
      units_used -= size;
      squeeze_table();
      return ffsa_pkg::ST_OK;
   endfunction

   function automatic grant_type predict_grant(input ffsa_pkg::req_kind_type kind,
                                               input int size, input int addr);
      grant_type g;
      int        got;
      got = 0;
      if (kind == ffsa_pkg::REQ_ALLOC) g.status = model_alloc(size, got);
      else                             g.status = model_free(size, addr);
      if (g.status != ffsa_pkg::ST_OK || kind != ffsa_pkg::REQ_ALLOC) got = 0;
      g.addr  = got[9:0];
      g.total = units_used[10:0];
      return g;
   endfunction

   // pick a range inside the allocated space (between free segments)
   function automatic bit pick_used_range(output int addr, output int size);
      int b[SEGS];
      int l[SEGS];
      int gs[SEGS+1];
      int ge[SEGS+1];
      int n, tb, tl, cur, pick, room;
      n = 0;
      for (int k = 0; k < seg_cnt; k++) begin
         b[k] = seg_base[k];
         l[k] = seg_len[k];
      end
      for (int i = 1; i < seg_cnt; i++) begin
         for (int j = i; j > 0 && b[j-1] > b[j]; j--) begin
            tb = b[j]; b[j] = b[j-1]; b[j-1] = tb;
            tl = l[j]; l[j] = l[j-1]; l[j-1] = tl;
         end
      end
      cur = 0;
      for (int k = 0; k < seg_cnt; k++) begin
         if (b[k] > cur) begin gs[n] = cur; ge[n] = b[k]; n++; end
         cur = b[k] + l[k] + ((l[k] == 0) ? 1 : 0);
      end
      if (cur < POOL) begin gs[n] = cur; ge[n] = POOL; n++; end
      addr = 0;
      size = 0;
      if (n == 0) return 0;
      pick = $urandom_range(0, n - 1);
      addr = $urandom_range(gs[pick], ge[pick] - 1);
      if ($urandom_range(0, 3) == 0) addr = gs[pick];
      room = ge[pick] - addr;
      size = ($urandom_range(0, 2) == 0) ? room : $urandom_range(1, (room > 24) ? 24 : room);
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // request side: one item per call, called at a rising edge
   // ------------------------------------------------------------------------
   task automatic send_req(input ffsa_pkg::req_kind_type kind, input int size,
                           input int addr);
      logic [10:0] sz;
      logic [9:0]  ad;
      sz = size[10:0];
      ad = addr[9:0];
      expected_grants.push_back(predict_grant(kind, sz, ad));
      while (!quiet && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, ad, sz};
      // ready is stable between the falling edge and the next rising edge
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
      end
   end

   always @(negedge clock) begin
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            errors++;
            $display("%0t: response item with none expected: tdata %h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            g = expected_grants.pop_front();
            if (rsp_tuser !== g.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, g.status, rsp_tuser);
            end
            if (rsp_tdata[9:0] !== g.addr) begin
               errors++;
               $display("%0t: alloc_addr expected %0d actual %0d", $time, g.addr,
                        rsp_tdata[9:0]);
            end
            if (rsp_tdata[20:10] !== g.total) begin
               errors++;
               $display("%0t: allocated_total expected %0d actual %0d", $time, g.total,
                        rsp_tdata[20:10]);
            end
            if (rsp_tdata[23:21] !== 3'b000) begin
               errors++;
               $display("%0t: pad expected 0 actual %0d", $time, rsp_tdata[23:21]);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_alloc_limits();
      send_req(ffsa_pkg::REQ_ALLOC, 0, 1023);     // zero size: ok, no change
      send_req(ffsa_pkg::REQ_ALLOC, 1025, 0);     // over the pool
      send_req(ffsa_pkg::REQ_ALLOC, 2047, 0);
      send_req(ffsa_pkg::REQ_FREE, 8, 0);         // more than allocated
      send_req(ffsa_pkg::REQ_ALLOC, 1024, 0);     // whole pool
      send_req(ffsa_pkg::REQ_ALLOC, 1, 0);        // not enough free total
      send_req(ffsa_pkg::REQ_FREE, 1025, 0);      // free over the pool
      send_req(ffsa_pkg::REQ_FREE, 16, 1016);     // runs past pool end
   endtask

   // pool fully used: scattered single-unit frees fill the table, one more
   // needs a new entry while the table is full
   task automatic test_table_full();
      for (int k = 0; k < SEGS + 1; k++) send_req(ffsa_pkg::REQ_FREE, 1, 4 * k);
   endtask

   task automatic test_coalesce();
      send_req(ffsa_pkg::REQ_FREE, 1, 0);         // starts at a free segment's start
      send_req(ffsa_pkg::REQ_FREE, 4, 2);         // free segment inside the range
      send_req(ffsa_pkg::REQ_FREE, 3, 1);         // both neighbors
      send_req(ffsa_pkg::REQ_FREE, 2, 5);         // preceding neighbor only
      send_req(ffsa_pkg::REQ_FREE, 2, 10);        // following neighbor only
      send_req(ffsa_pkg::REQ_ALLOC, 900, 0);      // larger than any segment and the free total
      send_req(ffsa_pkg::REQ_ALLOC, 6, 0);
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      quiet = 1'b1;
      for (int k = 0; k < 12; k++) send_req(ffsa_pkg::REQ_ALLOC, $urandom_range(0, 3), 0);
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      int a, s, r;
      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n < 300);             // long stretch without idling
         r = $urandom_range(0, 99);
         if (r < 10) begin
            send_req(ffsa_pkg::req_kind_type'($urandom_range(0, 1)),
                     $urandom_range(0, 2047), $urandom_range(0, 1023));
         end else if (r < 50) begin
            s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1024) : $urandom_range(1, 48);
            send_req(ffsa_pkg::REQ_ALLOC, s, $urandom_range(0, 1023));
         end else if (pick_used_range(a, s)) begin
            send_req(ffsa_pkg::REQ_FREE, s, a);
         end else begin
            send_req(ffsa_pkg::REQ_ALLOC, $urandom_range(1, 48), 0);
         end
      end
   endtask

   initial begin
      seg_cnt = 1;
      units_used = 0;
      for (int k = 0; k < SEGS; k++) begin
         seg_base[k] = 0;
         seg_len[k]  = 0;
      end
      seg_len[0] = POOL;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_alloc_limits();
      test_table_full();
      test_coalesce();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_ram.sv
rtl/core/ffsa_ctrl.sv
rtl/core/ffsa_dp.sv
rtl/core/first_fit_segment_allocator.sv
test/tb_first_fit_segment_allocator.sv
